[rtl/core/s2l_pkg.sv]
`default_nettype none

package s2l_pkg;

    localparam int Q_FRAC = 30;
    localparam longint unsigned Q30_ONE = 64'd1 << Q_FRAC;

    // linear channel value, q16, 0..65536
    localparam int LIN_W = 17;
    localparam int COEF_W = 24;
    localparam int PROD_W = COEF_W + LIN_W;
    localparam int SUM_W = 40;
    localparam int WP_SHIFT = 14;
    localparam int RNUM_W = SUM_W + WP_SHIFT;

    // white point ratio t in q30, below 2^31
    localparam int T_W = 32;
    localparam int RATIO_QUO_W = 32;

    // lab function output in q30, below 2^31
    localparam int F_W = 31;
    localparam int ROOT_BITS = 31;
    localparam int LAB_LAT = 2 * ROOT_BITS;

    // quotient bits resolved per divider stage
    localparam int DIV_STEP = 4;
    localparam int RATIO_STAGES = RATIO_QUO_W / DIV_STEP;

    // linear segment of the lab function: (t*24389 + 432*2^30 + 1566) / 3132
    localparam longint unsigned LIN_LIMIT = (64'd216 << Q_FRAC) / 64'd24389;
    localparam int LIN_T_W = 24;
    localparam int LNUM_W = 40;
    localparam int LIN_QUO_W = 28;
    localparam logic [14:0] LIN_SLOPE = 15'd24389;
    localparam longint unsigned LIN_OFFSET = (64'd432 << Q_FRAC) + 64'd1566;
    localparam longint unsigned LIN_DIV = 3132;

    localparam int QUEUE_DEPTH = 4;

    typedef logic [LIN_W-1:0] lin_t;

    typedef struct packed {
        lin_t blue;
        lin_t green;
        lin_t red;
    } lin_px_t;

    typedef lin_t lin_table_t [256];

    // srgb to xyz matrix, units of 1e-7
    localparam logic [COEF_W-1:0] MAT [3][3] = '{
        '{24'd4124564, 24'd3575761, 24'd1804375},
        '{24'd2126729, 24'd7151522, 24'd721750},
        '{24'd193339,  24'd1191920, 24'd9503041}
    };

    // d65 white point, units of 1e-7
    localparam longint unsigned RATIO_DIV [3] = '{64'd9504890, 64'd10000000, 64'd10888400};

    // srgb transfer curve, worked out once at elaboration
    function automatic lin_table_t build_lin_table();
        lin_table_t tab;
        longint unsigned u;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned r2;
        longint unsigned p;
        for (int c = 0; c < 256; c++) begin
            if (c <= 10) begin
                tab[c] = LIN_W'((64'(c) * 64'd6553600 + 64'd164730) / 64'd329460);
            end else begin
                u = (64'(1000 * c + 14025) << Q_FRAC) / 64'd269025;
                lo = 0;
                hi = Q30_ONE;
                while (lo < hi) begin
                    mid = lo + (hi - lo + 1) / 2;
                    r2 = (mid * mid) >> Q_FRAC;
                    if (((((r2 * r2) >> Q_FRAC) * mid) >> Q_FRAC) <= u) begin
                        lo = mid;
                    end else begin
                        hi = mid - 1;
                    end
                end
                r2 = (lo * lo) >> Q_FRAC;
                p = (((u * u) >> Q_FRAC) * r2) >> Q_FRAC;
                tab[c] = LIN_W'((p + 64'd8192) >> 14);
            end
        end
        return tab;
    endfunction

    localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

`default_nettype wire

[rtl/core/s2l_front.sv]
`default_nettype none

module s2l_front
    import s2l_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red, green, blue
    input  logic        q_full,
    output logic        q_push,
    output lin_px_t     q_data
);

    assign s_tready = !q_full;
    assign q_push = s_tvalid && !q_full;

    // linearise each channel through the transfer curve table
    assign q_data.red = LIN_TABLE[s_tdata[7:0]];
    assign q_data.green = LIN_TABLE[s_tdata[15:8]];
    assign q_data.blue = LIN_TABLE[s_tdata[23:16]];

endmodule

`default_nettype wire

[rtl/core/s2l_fifo.sv]
`default_nettype none

module s2l_fifo
    import s2l_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  lin_px_t wr_data,
    output logic    full,
    input  logic    pop,
    output lin_px_t rd_data,
    output logic    rd_valid
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    lin_px_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign rd_valid = cnt_reg != '0;
    assign full = cnt_reg == CNT_W'(QUEUE_DEPTH);

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == CNT_W'($past(cnt_reg) + CNT_W'(1)))
        else $error("queue fill did not rise on push");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> cnt_reg == CNT_W'($past(cnt_reg) - CNT_W'(1)))
        else $error("queue fill did not fall on pop");

endmodule

`default_nettype wire

[rtl/core/s2l_cdiv.sv]
`default_nettype none

// pipelined restoring divide by a constant, quotient must fit in QUO_W bits
module s2l_cdiv
    import s2l_pkg::*;
#(
    parameter longint unsigned DIVISOR = 3,
    parameter int NUM_W = 40,
    parameter int QUO_W = 32
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    output logic [QUO_W-1:0] quo
);

    localparam int REM_W = $clog2(DIVISOR);
    localparam int STAGES = QUO_W / DIV_STEP;
    localparam logic [REM_W:0] DIV_C = (REM_W + 1)'(DIVISOR);

    logic [REM_W-1:0] rem_reg [STAGES-1];
    logic [QUO_W-1:0] wrk_reg [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [REM_W-1:0] rem_in, rem_next;
        logic [QUO_W-1:0] wrk_in, wrk_next;

        if (s == 0) begin : g_first
            assign rem_in = REM_W'(num >> QUO_W);
            assign wrk_in = num[QUO_W-1:0];
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign wrk_in = wrk_reg[s-1];
        end

        // numerator bits shift out at the top, quotient bits in at the bottom
        always_comb begin
            logic [REM_W:0] trial;
            rem_next = rem_in;
            wrk_next = wrk_in;
            for (int k = 0; k < DIV_STEP; k++) begin
                trial = {rem_next, wrk_next[QUO_W-1]};
                wrk_next = {wrk_next[QUO_W-2:0], 1'b0};
                if (trial >= DIV_C) begin
                    rem_next = REM_W'(trial - DIV_C);
                    wrk_next[0] = 1'b1;
                end else begin
                    rem_next = trial[REM_W-1:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                wrk_reg[s] <= wrk_next;
            end
        end

        if (s < STAGES - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s] <= rem_next;
                end
            end
        end
    end

    assign quo = wrk_reg[STAGES-1];

endmodule

`default_nettype wire

[rtl/core/s2l_labf.sv]
`default_nettype none

// lab companding function: cube root above the knee, linear segment below
module s2l_labf
    import s2l_pkg::*;
(
    input  logic           aclk,
    input  logic           en,
    input  logic [T_W-1:0] t,
    output logic [F_W-1:0] f
);

    localparam int RB = ROOT_BITS;
    localparam int SQ_W = 2 * RB;
    localparam int CUBE_W = 64;
    localparam int DLY = LAB_LAT - 1 - LIN_QUO_W / DIV_STEP;

    typedef struct packed {
        logic [T_W-1:0] t;
        logic [RB-1:0]  r;
        logic           big;
    } root_t;

    root_t                 a_reg [RB];
    root_t                 b_reg [RB];
    logic [SQ_W-1:0]       sq_reg [RB];
    logic [LNUM_W-1:0]     lnum_reg;
    logic [LIN_QUO_W-1:0]  lquo;
    logic [LIN_QUO_W-1:0]  dly_reg [DLY];

    // one result bit per pair of stages, most significant first
    for (genvar k = 0; k < RB; k++) begin : g_bit
        localparam logic [RB-1:0] BIT = RB'(1) << (RB - 1 - k);
        root_t             src;
        root_t             a_next, b_next;
        logic [CUBE_W-1:0] cube;

        if (k == 0) begin : g_head
            always_comb begin
                src.t = t;
                src.r = '0;
                src.big = t > T_W'(LIN_LIMIT);
            end
        end else begin : g_tail
            assign src = b_reg[k-1];
        end

        always_comb begin
            a_next = src;
            a_next.r = src.r | BIT;
        end

        assign cube = CUBE_W'(sq_reg[k][SQ_W-1:Q_FRAC]) * CUBE_W'(a_reg[k].r);

        always_comb begin
            b_next = a_reg[k];
            if ((cube >> Q_FRAC) > CUBE_W'(a_reg[k].t)) begin
                b_next.r = a_reg[k].r & ~BIT;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_reg[k] <= a_next;
                sq_reg[k] <= SQ_W'(a_next.r) * SQ_W'(a_next.r);
                b_reg[k] <= b_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lnum_reg <= LNUM_W'(t[LIN_T_W-1:0]) * LNUM_W'(LIN_SLOPE) + LNUM_W'(LIN_OFFSET);
        end
    end

    s2l_cdiv #(
        .DIVISOR(LIN_DIV),
        .NUM_W  (LNUM_W),
        .QUO_W  (LIN_QUO_W)
    ) u_lin_div (
        .aclk(aclk),
        .en  (en),
        .num (lnum_reg),
        .quo (lquo)
    );

    // line the linear segment up with the root pipeline
    for (genvar d = 0; d < DLY; d++) begin : g_dly
        if (d == 0) begin : g_first
            always_ff @(posedge aclk) begin
                if (en) begin
                    dly_reg[d] <= lquo;
                end
            end
        end else begin : g_rest
            always_ff @(posedge aclk) begin
                if (en) begin
                    dly_reg[d] <= dly_reg[d-1];
                end
            end
        end
    end

    assign f = b_reg[RB-1].big ? b_reg[RB-1].r : F_W'(dly_reg[DLY-1]);

endmodule

`default_nettype wire

[rtl/core/s2l_back.sv]
`default_nettype none

module s2l_back
    import s2l_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  lin_px_t     q_data,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata
);

    localparam int VLD_LEN = 3 + RATIO_STAGES + LAB_LAT;
    localparam int ACC_W = 42;
    localparam int SH = Q_FRAC - FRAC_BITS;
    localparam longint LMAX_RAW = longint'(100) << FRAC_BITS;
    localparam longint LMAX_VAL = (LMAX_RAW > 32767) ? 32767 : LMAX_RAW;
    localparam logic [14:0] L_MAX = 15'(LMAX_VAL);
    localparam logic signed [ACC_W-1:0] L_MAX_S = ACC_W'(LMAX_VAL);
    localparam logic signed [ACC_W-1:0] AB_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] AB_MIN = -ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(longint'(1) << (SH - 1));
    localparam logic signed [ACC_W-1:0] L_OFS = ACC_W'(longint'(16) << Q_FRAC);
    localparam logic signed [ACC_W-1:0] K_L = ACC_W'(116);
    localparam logic signed [ACC_W-1:0] K_A = ACC_W'(500);
    localparam logic signed [ACC_W-1:0] K_B = ACC_W'(200);

    logic                     adv;
    logic [VLD_LEN-1:0]       vld_reg;
    logic                     m_tvalid_reg;
    lin_t                     lin_in [3];
    logic [PROD_W-1:0]        prod_reg [3][3];
    logic [RNUM_W-1:0]        num_reg [3];
    logic [T_W-1:0]           t_q [3];
    logic [F_W-1:0]           f_q [3];
    logic signed [ACC_W-1:0]  fxs, fys, fzs;
    logic signed [ACC_W-1:0]  l_acc_reg, a_acc_reg, b_acc_reg;
    logic signed [ACC_W-1:0]  l_sh, a_sh, b_sh;
    logic [14:0]              lightness_reg, lightness_next;
    logic [15:0]              green_red_reg, green_red_next;
    logic [15:0]              blue_yellow_reg, blue_yellow_next;

    // whole pipeline moves together, frozen only while the output holds a result
    assign adv = !m_tvalid_reg || m_tready;
    assign q_pop = adv && q_valid;

    assign lin_in[0] = q_data.red;
    assign lin_in[1] = q_data.green;
    assign lin_in[2] = q_data.blue;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= {vld_reg[VLD_LEN-2:0], q_valid};
            m_tvalid_reg <= vld_reg[VLD_LEN-1];
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_row
        localparam longint unsigned HALF = RATIO_DIV[i] / 2;

        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= PROD_W'(MAT[i][j]) * PROD_W'(lin_in[j]);
                end
                num_reg[i] <= (RNUM_W'(SUM_W'(prod_reg[i][0]) + SUM_W'(prod_reg[i][1])
                               + SUM_W'(prod_reg[i][2])) << WP_SHIFT) + RNUM_W'(HALF);
            end
        end

        s2l_cdiv #(
            .DIVISOR(RATIO_DIV[i]),
            .NUM_W  (RNUM_W),
            .QUO_W  (RATIO_QUO_W)
        ) u_div (
            .aclk(aclk),
            .en  (adv),
            .num (num_reg[i]),
            .quo (t_q[i])
        );

        s2l_labf u_lab (
            .aclk(aclk),
            .en  (adv),
            .t   (t_q[i]),
            .f   (f_q[i])
        );
    end

    assign fxs = ACC_W'(f_q[0]);
    assign fys = ACC_W'(f_q[1]);
    assign fzs = ACC_W'(f_q[2]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            l_acc_reg <= fys * K_L - L_OFS + RND;
            a_acc_reg <= (fxs - fys) * K_A + RND;
            b_acc_reg <= (fys - fzs) * K_B + RND;
        end
    end

    assign l_sh = l_acc_reg >>> SH;
    assign a_sh = a_acc_reg >>> SH;
    assign b_sh = b_acc_reg >>> SH;

    always_comb begin
        if (l_sh < 0) begin
            lightness_next = '0;
        end else if (l_sh > L_MAX_S) begin
            lightness_next = L_MAX;
        end else begin
            lightness_next = l_sh[14:0];
        end

        if (a_sh < AB_MIN) begin
            green_red_next = 16'h8000;
        end else if (a_sh > AB_MAX) begin
            green_red_next = 16'h7fff;
        end else begin
            green_red_next = a_sh[15:0];
        end

        if (b_sh < AB_MIN) begin
            blue_yellow_next = 16'h8000;
        end else if (b_sh > AB_MAX) begin
            blue_yellow_next = 16'h7fff;
        end else begin
            blue_yellow_next = b_sh[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lightness_reg <= lightness_next;
            green_red_reg <= green_red_next;
            blue_yellow_reg <= blue_yellow_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = {1'b0, blue_yellow_reg, green_red_reg, lightness_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> lightness_reg <= L_MAX)
        else $error("lightness above its limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");

endmodule

`default_nettype wire

[rtl/core/srgb_to_cielab_top.sv]
`default_nettype none

// srgb to cielab (d65) converter: takes one 8-bit srgb pixel per transaction and returns
// L*, a* and b* in fixed point with FRAC_BITS fraction bits, saturated to their ranges.
// One pixel is taken and one result given every clock when the output side keeps up;
// each pixel runs through the matrix products and sums, then the constant
// dividers for the white point ratios (8 stages) and the bit-per-two-stages cube root
// (62 stages) of the lab function. A four-entry queue after the transfer curve lookup
// lets the input side take up to four more pixels while a result waits at the output.
module srgb_to_cielab_top
    import s2l_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // lightness [14:0], green_red [30:15], blue_yellow [46:31]
);

    logic    q_full;
    logic    q_push;
    lin_px_t q_wr_data;
    logic    q_pop;
    lin_px_t q_rd_data;
    logic    q_valid;

    s2l_front u_front (
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wr_data)
    );

    s2l_fifo u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .rd_valid(q_valid)
    );

    s2l_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire
